// ----- design/dtm_pkg.sv -----
`default_nettype none

package dtm_pkg;

  // Field and port widths
  localparam int unsigned RAW_W       = 12;
  localparam int unsigned PULSE_W     = 11;
  localparam int unsigned FP_W        = 15;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 12;

  // Default EMA shift (legal 1..4)
  localparam int unsigned EMA_SHIFT_DEF = 3;

  // Pulse limits in microseconds
  localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
  localparam logic [PULSE_W-1:0] RC_TOP    = 11'd1880;
  localparam logic [PULSE_W-1:0] ESC_TOP   = 11'd2000;

  // x * 1000 / 880 == (x * 25) / 22; /22 as multiply by ceil(2^20 / 22), exact for x*25 < 47662
  localparam logic [15:0] RECIP_22    = 16'd47663;
  // /3000 as multiply by ceil(2^32 / 3000), exact below 6.1e6
  localparam logic [20:0] RECIP_3000  = 21'd1431656;

  // Register reset values
  localparam logic [11:0] SIGNAL_LOW_RST       = 12'd900;
  localparam logic [11:0] SIGNAL_HIGH_RST      = 12'd2200;
  localparam logic [10:0] IDLE_CUTOFF_RST      = 11'd1050;
  localparam logic [10:0] ROLL_CENTER_RST      = 11'd1400;
  localparam logic [7:0]  STICK_DEADZONE_RST   = 8'd15;
  localparam logic [10:0] MIX_ENABLE_POWER_RST = 11'd1100;
  localparam logic [8:0]  MIX_LIMIT_RST        = 9'd150;
  localparam logic [9:0]  SLEW_STEP_RST        = 10'd15;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SIGNAL_LOW       = 3'd0,
    REG_SIGNAL_HIGH      = 3'd1,
    REG_IDLE_CUTOFF      = 3'd2,
    REG_ROLL_CENTER      = 3'd3,
    REG_STICK_DEADZONE   = 3'd4,
    REG_MIX_ENABLE_POWER = 3'd5,
    REG_MIX_LIMIT        = 3'd6,
    REG_SLEW_STEP        = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [11:0] signal_low;
    logic [11:0] signal_high;
    logic [10:0] idle_cutoff;
    logic [10:0] roll_center;
    logic [7:0]  stick_deadzone;
    logic [10:0] mix_enable_power;
    logic [8:0]  mix_limit;
    logic [9:0]  slew_step;
  } cfg_t;

  // Step strobes from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic lost_reset;
    logic prep;
    logic scale;
    logic filter;
    logic mix_mul;
    logic mix_div;
    logic sides;
    logic slew;
    logic out_load;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_CHECK   = 4'd1,
    ST_SCALE   = 4'd2,
    ST_FILTER  = 4'd3,
    ST_MIX_MUL = 4'd4,
    ST_MIX_DIV = 4'd5,
    ST_SIDES   = 4'd6,
    ST_SLEW    = 4'd7,
    ST_DONE    = 4'd8
  } state_e;

endpackage

`default_nettype wire

// ----- design/dtm_cfg.sv -----
`default_nettype none

module dtm_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dtm_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [dtm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output dtm_pkg::cfg_t                         cfg_o
);
  import dtm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.signal_low       <= SIGNAL_LOW_RST;
      cfg_q.signal_high      <= SIGNAL_HIGH_RST;
      cfg_q.idle_cutoff      <= IDLE_CUTOFF_RST;
      cfg_q.roll_center      <= ROLL_CENTER_RST;
      cfg_q.stick_deadzone   <= STICK_DEADZONE_RST;
      cfg_q.mix_enable_power <= MIX_ENABLE_POWER_RST;
      cfg_q.mix_limit        <= MIX_LIMIT_RST;
      cfg_q.slew_step        <= SLEW_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_SIGNAL_LOW:       cfg_q.signal_low       <= cfg_wdata_i[11:0];
        REG_SIGNAL_HIGH:      cfg_q.signal_high      <= cfg_wdata_i[11:0];
        REG_IDLE_CUTOFF:      cfg_q.idle_cutoff      <= cfg_wdata_i[10:0];
        REG_ROLL_CENTER:      cfg_q.roll_center      <= cfg_wdata_i[10:0];
        REG_STICK_DEADZONE:   cfg_q.stick_deadzone   <= cfg_wdata_i[7:0];
        REG_MIX_ENABLE_POWER: cfg_q.mix_enable_power <= cfg_wdata_i[10:0];
        REG_MIX_LIMIT:        cfg_q.mix_limit        <= cfg_wdata_i[8:0];
        REG_SLEW_STEP:        cfg_q.slew_step        <= cfg_wdata_i[9:0];
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/dtm_ctrl.sv -----
`default_nettype none

module dtm_ctrl (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire logic     lost_i,
  output dtm_pkg::cmd_t cmd_o
);
  import dtm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (lost_i) begin
          cmd.lost_reset = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cmd.prep = 1'b1;
          state_d  = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_d   = ST_FILTER;
      end
      ST_FILTER: begin
        cmd.filter = 1'b1;
        state_d    = ST_MIX_MUL;
      end
      ST_MIX_MUL: begin
        cmd.mix_mul = 1'b1;
        state_d     = ST_MIX_DIV;
      end
      ST_MIX_DIV: begin
        cmd.mix_div = 1'b1;
        state_d     = ST_SIDES;
      end
      ST_SIDES: begin
        cmd.sides = 1'b1;
        state_d   = ST_SLEW;
      end
      ST_SLEW: begin
        cmd.slew = 1'b1;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

// ----- design/dtm_datapath.sv -----
`default_nettype none

module dtm_datapath #(
  parameter int unsigned EMA_SHIFT = dtm_pkg::EMA_SHIFT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  dtm_pkg::cfg_t                      cfg_i,
  input  dtm_pkg::cmd_t                      cmd_i,
  input  wire logic [dtm_pkg::RAW_W-1:0]     throttle_i,
  input  wire logic [dtm_pkg::RAW_W-1:0]     roll_i,
  output logic                               lost_o,
  output logic [dtm_pkg::PULSE_W-1:0]        left_o,
  output logic [dtm_pkg::PULSE_W-1:0]        right_o,
  output logic                               failsafe_o
);
  import dtm_pkg::*;

  localparam logic [FP_W-1:0] FP_RESET = FP_W'(32'(PULSE_MIN) << EMA_SHIFT);
  localparam logic [16:0]     HALF_W   = 17'(1 << (EMA_SHIFT - 1));
  localparam logic [16:0]     ROUND_W  = 17'((1 << EMA_SHIFT) - 1);

  function automatic logic [PULSE_W-1:0] clamp_rc(input logic [RAW_W-1:0] v);
    logic [PULSE_W-1:0] r;
    if (v < {1'b0, PULSE_MIN}) begin
      r = PULSE_MIN;
    end else if (v > {1'b0, RC_TOP}) begin
      r = RC_TOP;
    end else begin
      r = v[PULSE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [PULSE_W-1:0] clamp_esc(input logic signed [12:0] v);
    logic [PULSE_W-1:0] r;
    if (v < $signed({2'b0, PULSE_MIN})) begin
      r = PULSE_MIN;
    end else if (v > $signed({2'b0, ESC_TOP})) begin
      r = ESC_TOP;
    end else begin
      r = v[PULSE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [PULSE_W-1:0] slew_to(input logic [PULSE_W-1:0] tgt,
                                                 input logic [PULSE_W-1:0] cur,
                                                 input logic [9:0]         step);
    logic signed [12:0] d;
    logic signed [12:0] st;
    logic [PULSE_W-1:0] r;
    d  = $signed({2'b0, tgt}) - $signed({2'b0, cur});
    st = $signed({3'b0, step});
    if (d > st) begin
      r = cur + PULSE_W'(step);
    end else if (d < -st) begin
      r = cur - PULSE_W'(step);
    end else begin
      r = tgt;
    end
    return r;
  endfunction

  // item and intermediate registers
  logic [RAW_W-1:0]   thr_q, roll_q;
  logic [PULSE_W-1:0] roll_c_q;
  logic               idle_ok_q;
  logic [14:0]        y_q;
  logic [PULSE_W-1:0] tgt_q;
  logic               mix_en_q;
  logic               mix_neg_q;
  logic [20:0]        mprod_q;
  logic [9:0]         mix_mag_q;
  logic [PULSE_W-1:0] lt_q, rt_q;
  logic [PULSE_W-1:0] left_out_q, right_out_q;
  logic               fs_out_q;

  // state
  logic [FP_W-1:0]    fp_q;
  logic [PULSE_W-1:0] left_q, right_q;
  logic               fs_q;

  logic [PULSE_W-1:0] thr_c, roll_c;
  logic [9:0]         t_off;
  logic [14:0]        y;
  logic [29:0]        tgt_prod;
  logic [FP_W-1:0]    tgt_sh;
  logic signed [16:0] diff;
  logic [16:0]        inc, dec;
  logic [FP_W-1:0]    fp_next;
  logic [PULSE_W-1:0] power;
  logic signed [11:0] off, off_neg, dz_s;
  logic               in_dz;
  logic [10:0]        off_mag;
  logic [9:0]         pw;
  logic [20:0]        mprod;
  logic [41:0]        mq_prod;
  logic [9:0]         quo, lim;
  logic signed [12:0] pow_s, mix_s, lsum, rsum;

  assign lost_o = (thr_q < cfg_i.signal_low) || (thr_q > cfg_i.signal_high);

  // throttle to target: (t * 25) / 22
  assign thr_c    = clamp_rc(thr_q);
  assign roll_c   = clamp_rc(roll_q);
  assign t_off    = 10'(thr_c - PULSE_MIN);
  assign y        = 15'({t_off, 4'b0}) + 15'({t_off, 3'b0}) + 15'(t_off);
  assign tgt_prod = 30'(y_q) * 30'(RECIP_22);

  // rounded EMA: increases round half away from zero; decreases take ceil((|diff| + half) >> EMA_SHIFT)
  assign tgt_sh  = FP_W'(tgt_q) << EMA_SHIFT;
  assign diff    = $signed({2'b0, tgt_sh}) - $signed({2'b0, fp_q});
  assign inc     = ($unsigned(diff) + HALF_W) >> EMA_SHIFT;
  assign dec     = ((HALF_W - $unsigned(diff)) + ROUND_W) >> EMA_SHIFT;
  assign fp_next = diff[16] ? fp_q - dec[FP_W-1:0] : fp_q + inc[FP_W-1:0];
  assign power   = PULSE_W'(fp_q >> EMA_SHIFT);

  // roll offset times power above minimum, sign-magnitude
  assign off     = $signed({1'b0, roll_c_q}) - $signed({1'b0, cfg_i.roll_center});
  assign off_neg = -off;
  assign dz_s    = $signed({4'b0, cfg_i.stick_deadzone});
  assign in_dz   = (off > -dz_s) && (off < dz_s);
  assign off_mag = off[11] ? off_neg[10:0] : off[10:0];
  assign pw      = 10'(power - PULSE_MIN);
  assign mprod   = 21'(off_mag) * 21'(pw);

  // magnitude / 3000, truncation toward zero, then limit
  assign mq_prod = 42'(mprod_q) * 42'(RECIP_3000);
  assign quo     = mq_prod[41:32];
  assign lim     = {1'b0, cfg_i.mix_limit};

  assign pow_s = $signed({2'b0, power});
  assign mix_s = $signed({3'b0, mix_mag_q});
  assign lsum  = mix_neg_q ? pow_s - mix_s : pow_s + mix_s;
  assign rsum  = mix_neg_q ? pow_s + mix_s : pow_s - mix_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      thr_q  <= throttle_i;
      roll_q <= roll_i;
    end
    if (cmd_i.prep) begin
      y_q       <= y;
      idle_ok_q <= thr_c >= cfg_i.idle_cutoff;
      roll_c_q  <= roll_c;
    end
    if (cmd_i.scale) begin
      tgt_q <= idle_ok_q ? PULSE_MIN + PULSE_W'(tgt_prod[29:20]) : PULSE_MIN;
    end
    if (cmd_i.mix_mul) begin
      mix_en_q  <= power > cfg_i.mix_enable_power;
      mix_neg_q <= off[11];
      mprod_q   <= in_dz ? '0 : mprod;
    end
    if (cmd_i.mix_div) begin
      if (!mix_en_q) begin
        mix_mag_q <= '0;
      end else begin
        mix_mag_q <= (quo > lim) ? lim : quo;
      end
    end
    if (cmd_i.sides) begin
      lt_q <= clamp_esc(lsum);
      rt_q <= clamp_esc(rsum);
    end
    if (cmd_i.out_load) begin
      left_out_q  <= left_q;
      right_out_q <= right_q;
      fs_out_q    <= fs_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q    <= FP_RESET;
      left_q  <= PULSE_MIN;
      right_q <= PULSE_MIN;
      fs_q    <= 1'b0;
    end else if (cmd_i.lost_reset) begin
      fp_q    <= FP_RESET;
      left_q  <= PULSE_MIN;
      right_q <= PULSE_MIN;
      fs_q    <= 1'b1;
    end else begin
      if (cmd_i.prep) begin
        fs_q <= 1'b0;
      end
      if (cmd_i.filter) begin
        fp_q <= fp_next;
      end
      if (cmd_i.slew) begin
        left_q  <= slew_to(lt_q, left_q, cfg_i.slew_step);
        right_q <= slew_to(rt_q, right_q, cfg_i.slew_step);
      end
    end
  end

  assign left_o     = left_out_q;
  assign right_o    = right_out_q;
  assign failsafe_o = fs_out_q;

endmodule

`default_nettype wire

// ----- design/differential_throttle_mixer.sv -----
// Differential throttle mixer: one radio frame in, one pair of ESC pulses out.
//
// Input stream (s_axis): tdata carries throttle_pulse and roll_pulse, 12 bits
// each, in microseconds. Output stream (m_axis): tdata carries left_pulse and
// right_pulse (11 bits each, 1000..2000), tuser carries the failsafe flag.
// Registers are set through cfg_we_i / cfg_addr_i / cfg_wdata_i, one write per
// clock; the user must write only while no frame is in flight, which the block itself does not enforce.
//
// The controller steps the single datapath one step a cycle: a normal frame
// passes the check, target scaling, EMA, roll multiply, divide-by-3000, side
// clamps and slew, then loads its result into the output register; a
// lost-signal frame goes from the check straight to that load. One frame is
// worked on at a time; no new frame is taken until the last is loaded.
// The output register lets the next frame be accepted while a result waits;
// if the receiver stalls, that next frame waits in its last step until the
// output register frees, and the input then stops accepting.
// Reset restores register defaults, filter power to 1000 and both sides to
// 1000, and empties the output register.
`default_nettype none

module differential_throttle_mixer #(
  parameter int unsigned EMA_SHIFT = dtm_pkg::EMA_SHIFT_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tdata: throttle_pulse [11:0], roll_pulse [23:12]
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [dtm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tdata: left_pulse [10:0], right_pulse [21:11], zero [23:22]
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [dtm_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // tuser: failsafe [0]
  output logic                                   m_axis_tuser,
  input  wire logic                              cfg_we_i,
  input  wire logic [dtm_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [dtm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import dtm_pkg::*;

  cfg_t               cfg;
  cmd_t               cmd;
  logic               lost;
  logic [PULSE_W-1:0] left_pulse, right_pulse;

  dtm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sequencer: accept, step the datapath, hand result to the output register
  dtm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .lost_i      (lost),
    .cmd_o       (cmd)
  );

  dtm_datapath #(
    .EMA_SHIFT (EMA_SHIFT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .throttle_i (s_axis_tdata[RAW_W-1:0]),
    .roll_i     (s_axis_tdata[2*RAW_W-1:RAW_W]),
    .lost_o     (lost),
    .left_o     (left_pulse),
    .right_o    (right_pulse),
    .failsafe_o (m_axis_tuser)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - 2*PULSE_W)'(0), right_pulse, left_pulse};

endmodule

`default_nettype wire
